FILE: hw/rtl/cwt_pkg.sv
package cwt_pkg;

	localparam int MAX_WINDOW = 15;
	localparam int MAX_COLS   = 1024;
	localparam int PIXEL_BITS = 16;
	localparam int MAX_CHUNKS = 4;
	localparam int MAX_HEIGHT = 4095;
	localparam int CHUNK_BITS = 63;

	localparam int LS_ROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;

	// fixed field and register widths
	localparam int ROW_BITS      = 12;
	localparam int COL_BITS      = 10;
	localparam int CIDX_BITS     = 2;
	localparam int WIDTH_BITS    = 11;
	localparam int HEIGHT_BITS   = 12;
	localparam int WSIZE_BITS    = 4;
	localparam int CCOUNT_BITS   = 3;
	localparam int CFG_DATA_BITS = 12;
	localparam int CFG_IDX_BITS  = 2;

	localparam int ADDR_BITS    = $clog2(MAX_COLS);
	localparam int WIN_BITS     = $clog2(MAX_WINDOW + 1);
	localparam int WIN_IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SQ_BITS      = 2 * WIN_BITS;
	localparam int NCH_MAX      = (MAX_WINDOW * MAX_WINDOW + CHUNK_BITS - 1) / CHUNK_BITS;
	localparam int NCH_BITS     = $clog2(((NCH_MAX > MAX_CHUNKS) ? NCH_MAX : MAX_CHUNKS) + 1);
	localparam int KSEL_BITS    = (NCH_MAX > 1) ? $clog2(NCH_MAX) : 1;
	localparam int PACK_BITS    = NCH_MAX * CHUNK_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_WSIZE  = 2'd2,
		REG_CCOUNT = 2'd3
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pix_t;
	typedef logic [MAX_WINDOW-1:0][PIXEL_BITS-1:0] wcol_t;
	typedef logic [LS_ROWS-1:0][PIXEL_BITS-1:0] ls_word_t;
	// indexed [column][row]
	typedef logic [MAX_WINDOW-1:0][MAX_WINDOW-1:0] cmp_grid_t;
	typedef logic [NCH_MAX-1:0][CHUNK_BITS-1:0] chunk_set_t;

	typedef struct packed {
		logic [ROW_BITS-1:0] crow;
		logic [COL_BITS-1:0] ccol;
		logic [WIN_BITS-1:0] wsize;
		logic [NCH_BITS-1:0] nch;
	} item_t;

	// chunks a full window of side w fills
	function automatic logic [NCH_BITS-1:0] chunks_needed(input logic [WIN_BITS-1:0] w);
		logic [SQ_BITS-1:0] sq;
		logic [NCH_BITS-1:0] n;
		sq = SQ_BITS'(w) * SQ_BITS'(w);
		n = NCH_BITS'(1);
		for (int k = 1; k < NCH_MAX; k++) begin
			if (int'(sq) > k * CHUNK_BITS)
				n = NCH_BITS'(n + 1'b1);
		end
		return n;
	endfunction

endpackage

FILE: hw/rtl/cwt_cell.sv
module cwt_cell import cwt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  wcol_t                 col_in,
	input  pix_t                  centre,
	output wcol_t                 col_out,
	output logic [MAX_WINDOW-1:0] above
);

	wcol_t col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// bit set where the centre is below this pixel
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++)
			above[i] = centre < col_q[i];
	end

endmodule

FILE: hw/rtl/cwt_line_store.sv
module cwt_line_store import cwt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output ls_word_t             rd_data,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  ls_word_t             wr_data
);

	ls_word_t mem [MAX_COLS];
	ls_word_t rd_q;
	logic [ADDR_BITS-1:0] rd_addr_q;
	logic                 lw_valid_q;
	logic [ADDR_BITS-1:0] lw_addr_q;
	ls_word_t             lw_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_addr_q <= rd_addr;
		if (wr_en) begin
			lw_addr_q <= wr_addr;
			lw_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (wr_en) begin
			lw_valid_q <= 1'b1;
		end
	end

	// a read taken on the edge of a write to the same column sees the new data
	assign rd_data = (lw_valid_q && lw_addr_q == rd_addr_q) ? lw_data_q : rd_q;

endmodule

FILE: hw/rtl/cwt_packer.sv
module cwt_packer import cwt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  item_t                 item,
	input  cmp_grid_t             grid,
	output logic                  ready,
	output logic                  chunk_valid,
	input  logic                  chunk_stall,
	output logic [ROW_BITS-1:0]   centre_row,
	output logic [COL_BITS-1:0]   centre_col,
	output logic [CIDX_BITS-1:0]  chunk_index,
	output logic [CHUNK_BITS-1:0] chunk_bits,
	output logic                  last_chunk
);

	logic                 v_s3;
	item_t                item_s3;
	cmp_grid_t            grid_s3;
	logic [KSEL_BITS-1:0] k_q;

	logic                  ov_q;
	logic [ROW_BITS-1:0]   crow_q;
	logic [COL_BITS-1:0]   ccol_q;
	logic [CIDX_BITS-1:0]  cidx_q;
	logic [CHUNK_BITS-1:0] bits_q;
	logic                  last_q;

	logic [PACK_BITS-1:0] by_w [MAX_WINDOW];
	chunk_set_t           chunks;
	logic                 ld_out;
	logic                 last;

	// row-major order of the window that sits in the bottom-right corner
	for (genvar gw = 1; gw <= MAX_WINDOW; gw++) begin : g_size
		for (genvar gp = 0; gp < PACK_BITS; gp++) begin : g_bit
			if (gp < gw * gw) begin : g_used
				localparam int PR = MAX_WINDOW - gw + gp / gw;
				localparam int PC = MAX_WINDOW - gw + gp % gw;
				assign by_w[gw-1][gp] = grid_s3[PC][PR];
			end else begin : g_pad
				assign by_w[gw-1][gp] = 1'b0;
			end
		end
	end

	assign chunks = by_w[WIN_IDX_BITS'(item_s3.wsize - 1'b1)];
	assign ld_out = v_s3 && (!ov_q || !chunk_stall);
	assign last   = (NCH_BITS'(k_q) + 1'b1) == item_s3.nch;
	assign ready  = !v_s3 || (ld_out && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			k_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if (load)
				v_s3 <= 1'b1;
			else if (ld_out && last)
				v_s3 <= 1'b0;
			if (load)
				k_q <= '0;
			else if (ld_out)
				k_q <= KSEL_BITS'(k_q + 1'b1);
			if (ld_out)
				ov_q <= 1'b1;
			else if (!chunk_stall)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s3 <= item;
			grid_s3 <= grid;
		end
		if (ld_out) begin
			crow_q <= item_s3.crow;
			ccol_q <= item_s3.ccol;
			cidx_q <= CIDX_BITS'(k_q);
			bits_q <= chunks[k_q];
			last_q <= last;
		end
	end

	assign chunk_valid = ov_q;
	assign centre_row  = crow_q;
	assign centre_col  = ccol_q;
	assign chunk_index = cidx_q;
	assign chunk_bits  = bits_q;
	assign last_chunk  = last_q;

endmodule

FILE: hw/rtl/census_window_transform.sv
// channel   direction  handshake                 payload
// pixel     in         pixel_valid/pixel_stall   pixel_value
// chunk     out        chunk_valid/chunk_stall   centre_row centre_col chunk_index
//                                                chunk_bits last_chunk
// config    in         cfg_we                    cfg_index cfg_data
//
// a pixel that makes no census word can be taken every cycle while no earlier
// census word holds the window; a pixel that makes n chunks (n up to 4) sends
// them in turn on the single chunk output, so the output port sets the rate.
// line store read issued on accept, window column shifts when s1 advances.
// reset clears counters, window cells and handshake state; no clearing pass.
// chunk_stall backs up through the packer into the window and to pixel_stall.
module census_window_transform import cwt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  logic                     pixel_valid,
	output logic                     pixel_stall,
	input  logic [PIXEL_BITS-1:0]    pixel_value,
	output logic                     chunk_valid,
	input  logic                     chunk_stall,
	output logic [ROW_BITS-1:0]      centre_row,
	output logic [COL_BITS-1:0]      centre_col,
	output logic [CIDX_BITS-1:0]     chunk_index,
	output logic [CHUNK_BITS-1:0]    chunk_bits,
	output logic                     last_chunk
);

	logic [WIDTH_BITS-1:0]  width_q;
	logic [HEIGHT_BITS-1:0] height_q;
	logic [WSIZE_BITS-1:0]  wsize_q;
	logic [CCOUNT_BITS-1:0] ccount_q;

	logic [WIN_BITS-1:0]    w_eff;
	logic [WIDTH_BITS-1:0]  wd_eff;
	logic [HEIGHT_BITS-1:0] ht_eff;
	logic [NCH_BITS-1:0]    lim_eff;
	logic [NCH_BITS-1:0]    need;

	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS:0]   row_nx;
	logic [COL_BITS:0]   col_nx;
	logic [WIN_BITS-1:0] half;
	logic                hit;
	item_t               item;
	logic                pix_acc;

	logic                 v_s1;
	pix_t                 pix_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic                 hit_s1;
	item_t                item_s1;
	logic                 adv_s1;

	logic  v_s2;
	item_t item_s2;
	logic  mv_s2;
	logic  pk_ready;

	ls_word_t ls_rd;
	ls_word_t ls_new;
	wcol_t    new_col;
	wcol_t    win [MAX_WINDOW];
	wcol_t    cell_in [MAX_WINDOW];
	cmp_grid_t grid;
	logic [WIN_BITS:0]     w_up;
	logic [WIN_IDX_BITS-1:0] ctr;
	pix_t                  centre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_BITS'(640);
			height_q <= HEIGHT_BITS'(480);
			wsize_q  <= WSIZE_BITS'(7);
			ccount_q <= CCOUNT_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_BITS-1:0];
				REG_WSIZE:  wsize_q  <= cfg_data[WSIZE_BITS-1:0];
				REG_CCOUNT: ccount_q <= cfg_data[CCOUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (wsize_q == '0)
			w_eff = WIN_BITS'(1);
		else if (int'(wsize_q) > MAX_WINDOW)
			w_eff = WIN_BITS'(MAX_WINDOW);
		else
			w_eff = WIN_BITS'(wsize_q);
		if (width_q == '0)
			wd_eff = WIDTH_BITS'(1);
		else if (int'(width_q) > MAX_COLS)
			wd_eff = WIDTH_BITS'(MAX_COLS);
		else
			wd_eff = width_q;
		if (height_q == '0)
			ht_eff = HEIGHT_BITS'(1);
		else if (int'(height_q) > MAX_HEIGHT)
			ht_eff = HEIGHT_BITS'(MAX_HEIGHT);
		else
			ht_eff = height_q;
		if (int'(ccount_q) > MAX_CHUNKS)
			lim_eff = NCH_BITS'(MAX_CHUNKS);
		else
			lim_eff = NCH_BITS'(ccount_q);
	end

	assign need    = chunks_needed(w_eff);
	assign pix_acc = pixel_valid && !pixel_stall;
	assign row_nx  = {1'b0, row_q} + 1'b1;
	assign col_nx  = {1'b0, col_q} + 1'b1;
	assign half    = w_eff >> 1;

	assign hit = (row_nx >= (ROW_BITS+1)'(w_eff)) && (col_nx >= (COL_BITS+1)'(w_eff)) &&
		(row_nx < (ROW_BITS+1)'(ht_eff)) && (col_nx < (COL_BITS+1)'(wd_eff)) &&
		(lim_eff != '0);

	always_comb begin
		item.crow  = ROW_BITS'(row_nx - (ROW_BITS+1)'(w_eff) + (ROW_BITS+1)'(half));
		item.ccol  = COL_BITS'(col_nx - (COL_BITS+1)'(w_eff) + (COL_BITS+1)'(half));
		item.wsize = w_eff;
		item.nch   = (need > lim_eff) ? lim_eff : need;
	end

	// raster position, wraps at row end and frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_acc) begin
			if (col_nx >= (COL_BITS+1)'(wd_eff)) begin
				col_q <= '0;
				if (row_nx >= (ROW_BITS+1)'(ht_eff))
					row_q <= '0;
				else
					row_q <= row_nx[ROW_BITS-1:0];
			end else begin
				col_q <= col_nx[COL_BITS-1:0];
			end
		end
	end

	// the window may only move once the pending census word has left it
	assign adv_s1      = v_s1 && (!v_s2 || mv_s2);
	assign pixel_stall = v_s1 && !adv_s1;
	assign mv_s2       = v_s2 && pk_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (pix_acc)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (adv_s1)
				v_s2 <= hit_s1;
			else if (mv_s2)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1  <= pixel_value;
			addr_s1 <= ADDR_BITS'(col_q);
			hit_s1  <= hit;
			item_s1 <= item;
		end
		if (adv_s1)
			item_s2 <= item_s1;
	end

	cwt_line_store u_line_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (pix_acc),
		.rd_addr (ADDR_BITS'(col_q)),
		.rd_data (ls_rd),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data (ls_new)
	);

	always_comb begin
		ls_new[0] = pix_s1;
		for (int k = 1; k < LS_ROWS; k++)
			ls_new[k] = ls_rd[k-1];
		for (int i = 0; i < MAX_WINDOW - 1; i++)
			new_col[i] = ls_rd[MAX_WINDOW-2-i];
		new_col[MAX_WINDOW-1] = pix_s1;
	end

	// centre sits at MAX_WINDOW minus half the window, rounded up
	assign w_up   = {1'b0, item_s2.wsize} + 1'b1;
	assign ctr    = WIN_IDX_BITS'((WIN_BITS+1)'(MAX_WINDOW) - (w_up >> 1));
	assign centre = win[ctr][ctr];

	for (genvar gj = 0; gj < MAX_WINDOW; gj++) begin : g_col
		if (gj == MAX_WINDOW - 1) begin : g_head
			assign cell_in[gj] = new_col;
		end else begin : g_link
			assign cell_in[gj] = win[gj+1];
		end
		cwt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (adv_s1),
			.col_in  (cell_in[gj]),
			.centre  (centre),
			.col_out (win[gj]),
			.above   (grid[gj])
		);
	end

	cwt_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (mv_s2),
		.item        (item_s2),
		.grid        (grid),
		.ready       (pk_ready),
		.chunk_valid (chunk_valid),
		.chunk_stall (chunk_stall),
		.centre_row  (centre_row),
		.centre_col  (centre_col),
		.chunk_index (chunk_index),
		.chunk_bits  (chunk_bits),
		.last_chunk  (last_chunk)
	);

`ifndef SYNTHESIS
	a_chunk_follows: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && !chunk_stall && !last_chunk |=>
			chunk_valid && chunk_index == CIDX_BITS'($past(chunk_index) + 1'b1))
		else $error("next chunk of a pixel missing or out of order");

	a_new_pixel_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		chunk_valid && !chunk_stall && last_chunk |=> !chunk_valid || chunk_index == '0)
		else $error("word after a last chunk does not start a new pixel");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> v_s1)
		else $error("accepted pixel word lost before the window");
`endif

endmodule
